[rtl/llf_pkg.sv]
// Shared types, register indexes and helpers for the lead-lag filter step block.
// No dependencies.
package llf_pkg;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] sample_in;
   } llf_req_type;

   typedef struct packed {
      logic signed [31:0] y_out;
      logic signed [31:0] state_out;
   } llf_rsp_type;

   typedef struct packed {
      logic [31:0] gain_k;
      logic [31:0] coef_half_step_over_lag;
      logic [31:0] coef_lag_recip;
      logic [31:0] coef_lead_over_lag;
      logic [31:0] coef_lag_over_lead_minus_one;
      logic [31:0] coef_half_step_over_lead;
      logic [1:0]  step_mode;
      logic [4:0]  slice_count;
   } llf_cfg_type;

   localparam logic [2:0] CSR_GAIN_K       = 3'd0;
   localparam logic [2:0] CSR_HSTEP_LAG    = 3'd1;
   localparam logic [2:0] CSR_LAG_RECIP    = 3'd2;
   localparam logic [2:0] CSR_LEAD_LAG     = 3'd3;
   localparam logic [2:0] CSR_LAG_LEAD_M1  = 3'd4;
   localparam logic [2:0] CSR_HSTEP_LEAD   = 3'd5;
   localparam logic [2:0] CSR_STEP_MODE    = 3'd6;
   localparam logic [2:0] CSR_SLICE_COUNT  = 3'd7;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_SMALL  = 2'd1;
   localparam logic       REQ_STEP    = 1'b0;
   localparam logic       REQ_INIT    = 1'b1;
   localparam logic [31:0] ONE_Q24    = 32'h0100_0000;

   // saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] llf_sat(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (v < -40'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

[rtl/llf_mul.sv]
// Shared coefficient multiplier: Q8.24 x Q16.16, round half up, saturate.
// Depends on llf_pkg. Registers the product, then the rounded and saturated result; done follows start.
module llf_mul import llf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        coef,
   input  logic signed [31:0] val,
   output logic               done,
   output logic signed [31:0] result
);
   logic signed [63:0] prod_ff;
   logic               v1_ff, v2_ff;
   logic signed [31:0] res_ff;
   logic signed [63:0] rnd;
   logic signed [39:0] shf;

   assign rnd = prod_ff + 64'sd8388608;
   assign shf = rnd[63:24];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
      prod_ff <= $signed(coef) * val;
      res_ff  <= llf_sat(shf);
   end

   assign done   = v2_ff;
   assign result = res_ff;
endmodule

[rtl/llf_core.sv]
// Sequencer and datapath of the lead-lag step: slice divider, operand selection,
// filter state. Depends on llf_pkg and llf_mul.
module llf_core import llf_pkg::*; #(
   parameter int MAX_SLICES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  llf_cfg_type cfg,
   input  logic        in_valid,
   output logic        in_ready,
   input  llf_req_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output llf_rsp_type out_data
);
   localparam int NW = $clog2(MAX_SLICES + 1);
   localparam int CW = (NW > 5) ? NW : 5;
   localparam logic [CW-1:0] MAXC = CW'(MAX_SLICES);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_SLICE = 3'd2;
   localparam logic [2:0] ST_ISSUE = 3'd3;
   localparam logic [2:0] ST_WAIT  = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   localparam logic [2:0] OP_KX = 3'd0;
   localparam logic [2:0] OP_T  = 3'd1;
   localparam logic [2:0] OP_S  = 3'd2;
   localparam logic [2:0] OP_U  = 3'd3;
   localparam logic [2:0] OP_Y  = 3'd4;
   localparam logic [2:0] OP_Z  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic signed [31:0] x_ff, x_in, xi_ff, xi_in, kx_ff, kx_in, t_ff, t_in;
   logic signed [31:0] s_ff, s_in, z_ff, z_in, y_ff, y_in, p_ff, p_in;
   logic        bypass_ff, bypass_in, small_ff, small_in, neg_ff, neg_in;
   logic [NW-1:0] n_ff, n_in, slice_ff, slice_in, rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in, qacc_ff, qacc_in;
   logic [NW:0] racc_ff, racc_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic        mul_start, mul_done;
   logic [31:0] mul_coef;
   logic signed [31:0] mul_val, mul_res;

   logic [CW-1:0] sc_ext;
   logic [NW-1:0] n_calc;
   logic signed [32:0] diff;
   logic [32:0] mag;
   logic [NW:0] rem_sh, rsum;
   logic [32:0] qsum;
   logic signed [39:0] xsum;

   llf_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .coef(mul_coef),
      .val(mul_val), .done(mul_done), .result(mul_res)
   );

   always_comb begin
      sc_ext = CW'(cfg.slice_count);
      if (cfg.slice_count == 5'd0) n_calc = NW'(1);
      else if (sc_ext > MAXC) n_calc = NW'(MAXC);
      else n_calc = NW'(sc_ext);
      diff = {in_data.sample_in[31], in_data.sample_in} - {p_ff[31], p_ff};
      mag  = diff[32] ? 33'(-diff) : 33'(diff);
      rem_sh = {rem_ff, quo_ff[32]};
      rsum = racc_ff + {1'b0, rem_ff};
      qsum = qacc_ff + quo_ff;
      if (rsum >= {1'b0, n_ff}) begin
         rsum = rsum - {1'b0, n_ff};
         qsum = qsum + 33'd1;
      end
      xsum = neg_ff ? (40'(p_ff) - 40'($signed({1'b0, qsum})))
                    : (40'(p_ff) + 40'($signed({1'b0, qsum})));
   end

   always_comb begin
      case (op_ff)
         OP_KX: begin mul_coef = cfg.gain_k; mul_val = xi_ff; end
         OP_T:  begin mul_coef = cfg.coef_half_step_over_lag; mul_val = kx_ff; end
         OP_S:  begin mul_coef = cfg.coef_lag_recip; mul_val = t_ff; end
         OP_U:  begin mul_coef = cfg.coef_lag_over_lead_minus_one; mul_val = s_ff; end
         OP_Y:  begin mul_coef = cfg.coef_lead_over_lag; mul_val = t_ff; end
         default: begin mul_coef = cfg.coef_half_step_over_lead; mul_val = t_ff; end
      endcase
   end

   always_comb begin
      state_in = state_ff; op_in = op_ff;
      x_in = x_ff; xi_in = xi_ff; kx_in = kx_ff; t_in = t_ff;
      s_in = s_ff; z_in = z_ff; y_in = y_ff; p_in = p_ff;
      bypass_in = bypass_ff; small_in = small_ff; neg_in = neg_ff;
      n_in = n_ff; slice_in = slice_ff; rem_in = rem_ff; quo_in = quo_ff;
      qacc_in = qacc_ff; racc_in = racc_ff; cnt_in = cnt_ff;
      mul_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               x_in  = in_data.sample_in;
               xi_in = in_data.sample_in;
               bypass_in = (in_data.req_type == REQ_INIT) || cfg.step_mode[1];
               small_in  = (in_data.req_type != REQ_INIT) && (cfg.step_mode == MODE_SMALL);
               neg_in = diff[32];
               n_in = n_calc;
               op_in = OP_KX;
               if ((in_data.req_type != REQ_INIT) && (cfg.step_mode == MODE_SMALL)) begin
                  quo_in = mag; rem_in = '0; cnt_in = '0;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_DIV: begin
            // restoring divide of |x - prev| by the slice count
            if (rem_sh >= {1'b0, n_ff}) begin
               rem_in = NW'(rem_sh - {1'b0, n_ff});
               quo_in = {quo_ff[31:0], 1'b1};
            end else begin
               rem_in = rem_sh[NW-1:0];
               quo_in = {quo_ff[31:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) begin
               qacc_in = '0; racc_in = '0; slice_in = '0;
               state_in = ST_SLICE;
            end
         end
         ST_SLICE: begin
            qacc_in = qsum; racc_in = rsum;
            xi_in = llf_sat(xsum);
            slice_in = slice_ff + NW'(1);
            op_in = OP_KX;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            mul_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_done) begin
               op_in = op_ff + 3'd1;
               state_in = ST_ISSUE;
               case (op_ff)
                  OP_KX: begin
                     kx_in = mul_res;
                     if (bypass_ff) begin
                        s_in = mul_res; z_in = mul_res; y_in = mul_res;
                        state_in = ST_FIN;
                     end
                  end
                  OP_T: t_in = llf_sat(40'(z_ff) + 40'(mul_res));
                  OP_S: s_in = mul_res;
                  OP_U: t_in = llf_sat(40'(kx_ff) + 40'(mul_res));
                  OP_Y: begin
                     y_in = mul_res;
                     t_in = llf_sat(40'(mul_res) - 40'(s_ff));
                  end
                  default: begin
                     z_in = llf_sat(40'(s_ff) + 40'(mul_res));
                     state_in = (small_ff && (slice_ff != n_ff)) ? ST_SLICE : ST_FIN;
                  end
               endcase
            end
         end
         ST_FIN: begin
            if (out_ready) begin
               p_in = x_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         s_ff <= '0; z_ff <= '0; p_ff <= '0;
      end else begin
         state_ff <= state_in;
         s_ff <= s_in; z_ff <= z_in; p_ff <= p_in;
      end
      op_ff <= op_in; x_ff <= x_in; xi_ff <= xi_in; kx_ff <= kx_in; t_ff <= t_in;
      y_ff <= y_in; bypass_ff <= bypass_in; small_ff <= small_in; neg_ff <= neg_in;
      n_ff <= n_in; slice_ff <= slice_in; rem_ff <= rem_in; quo_ff <= quo_in;
      qacc_ff <= qacc_in; racc_ff <= racc_in; cnt_ff <= cnt_in;
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_FIN);
   assign out_data.y_out     = y_ff;
   assign out_data.state_out = s_ff;
endmodule

[rtl/lead_lag_filter_step_top.sv]
// Top level of the trapezoidal lead-lag filter step: CSR bank, core, result register.
// Depends on llf_pkg, llf_core, llf_mul.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | llf_req_type (req_type, sample_in)
//  rsp     | out       | rsp_valid/rsp_ready  | llf_rsp_type (y_out, state_out)
//  csr     | in        | csr_valid/csr_ready  | csr_index (3b), csr_wdata (32b)
//
// Each multiply runs on the shared 2-stage multiplier, the core waiting for its done;
// an initialise or large-mode transaction runs only k*x, a normal step the chain of six
// multiplies, a small step a bit-serial divide of the input delta, then n slices of it.
// Reset clears control, filter state and CSRs to their defaults; no clearing pass.
// A finished result waits in the rsp register; the core takes the next req meanwhile
// and holds its own result if rsp is still stalled.
module lead_lag_filter_step_top import llf_pkg::*; #(
   parameter int MAX_SLICES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  llf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output llf_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   llf_cfg_type cfg_ff, cfg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   llf_rsp_type rsp_data_ff, rsp_data_in;
   logic        core_out_valid, core_out_ready;
   llf_rsp_type core_out_data;

   // CSR writes always accepted; software must only write while idle (not enforced here)
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN_K:      cfg_in.gain_k = csr_wdata;
            CSR_HSTEP_LAG:   cfg_in.coef_half_step_over_lag = csr_wdata;
            CSR_LAG_RECIP:   cfg_in.coef_lag_recip = csr_wdata;
            CSR_LEAD_LAG:    cfg_in.coef_lead_over_lag = csr_wdata;
            CSR_LAG_LEAD_M1: cfg_in.coef_lag_over_lead_minus_one = csr_wdata;
            CSR_HSTEP_LEAD:  cfg_in.coef_half_step_over_lead = csr_wdata;
            CSR_STEP_MODE:   cfg_in.step_mode = csr_wdata[1:0];
            CSR_SLICE_COUNT: cfg_in.slice_count = csr_wdata[4:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   llf_core #(.MAX_SLICES(MAX_SLICES)) u_core (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .out_valid(core_out_valid), .out_ready(core_out_ready), .out_data(core_out_data)
   );

   // output register: load when empty or being drained
   assign core_out_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (core_out_valid && core_out_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_out_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_k <= ONE_Q24;
         cfg_ff.coef_half_step_over_lag <= '0;
         cfg_ff.coef_lag_recip <= ONE_Q24;
         cfg_ff.coef_lead_over_lag <= ONE_Q24;
         cfg_ff.coef_lag_over_lead_minus_one <= '0;
         cfg_ff.coef_half_step_over_lead <= '0;
         cfg_ff.step_mode <= MODE_NORMAL;
         cfg_ff.slice_count <= 5'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

[rtl/llf_checker.sv]
// Port-level checks for lead_lag_filter_step_top, attached by bind.
// Depends on llf_pkg.
module llf_checker import llf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input llf_rsp_type rsp_data
);
   // a step is never finished in the accepting cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after accept");

   // nothing pending after reset, ready to take a transaction
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("bad state after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled rsp changed");
endmodule

bind lead_lag_filter_step_top llf_checker u_llf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
